// File: design/jsts_pkg.sv
// ----------------------------------------------------------------------------
// jsts_pkg
// Types, character codes and small lookup functions shared by the JSON scalar
// token scanner modules.
// ----------------------------------------------------------------------------
package jsts_pkg;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_LIT,
      PH_INT,
      PH_FRAC,
      PH_EXPSIGN,
      PH_EXPDIG
   } phase_type;

   typedef enum logic [3:0] {
      TOK_INT       = 4'd0,
      TOK_NAT       = 4'd1,
      TOK_REAL      = 4'd2,
      TOK_TRUE      = 4'd3,
      TOK_FALSE     = 4'd4,
      TOK_NULL      = 4'd5,
      TOK_OTHER     = 4'd6,
      TOK_ERR_NUM   = 4'd7,
      TOK_ERR_REAL  = 4'd8,
      TOK_ERR_TRUE  = 4'd9,
      TOK_ERR_FALSE = 4'd10,
      TOK_ERR_NULL  = 4'd11,
      TOK_END       = 4'd12
   } tok_kind_type;

   localparam logic [1:0] LIT_TRUE  = 2'd0;
   localparam logic [1:0] LIT_FALSE = 2'd1;
   localparam logic [1:0] LIT_NULL  = 2'd2;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_UP_E  = 8'h45;
   localparam logic [7:0] CH_A     = 8'h61;
   localparam logic [7:0] CH_E     = 8'h65;
   localparam logic [7:0] CH_F     = 8'h66;
   localparam logic [7:0] CH_L     = 8'h6C;
   localparam logic [7:0] CH_N     = 8'h6E;
   localparam logic [7:0] CH_R     = 8'h72;
   localparam logic [7:0] CH_S     = 8'h73;
   localparam logic [7:0] CH_T     = 8'h74;
   localparam logic [7:0] CH_U     = 8'h75;

   localparam int FIFO_DEPTH  = 4;
   localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
   localparam int RSP_TDATA_W = 80;

   typedef struct packed {
      tok_kind_type token_kind;
      logic [63:0]  token_value;
      logic         overflow_flag;
      logic [7:0]   passed_byte;
      logic         last_result;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type res_first;
      result_type res_second;
   } result_pair_type;

   function automatic logic is_digit(input logic [7:0] b);
      return (b >= CH_0) && (b <= CH_9);
   endfunction

   function automatic logic is_space(input logic [7:0] b);
      return (b == CH_NUL) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR) ||
             (b == CH_SPACE);
   endfunction

   function automatic logic [7:0] lit_char(input logic [1:0] which, input logic [1:0] pos);
      logic [7:0] ch;
      ch = CH_NUL;
      unique case (which)
         LIT_TRUE: begin
            unique case (pos)
               2'd0: ch = CH_R;
               2'd1: ch = CH_U;
               2'd2: ch = CH_E;
               2'd3: ch = CH_NUL;
            endcase
         end
         LIT_FALSE: begin
            unique case (pos)
               2'd0: ch = CH_A;
               2'd1: ch = CH_L;
               2'd2: ch = CH_S;
               2'd3: ch = CH_E;
            endcase
         end
         default: begin
            unique case (pos)
               2'd0: ch = CH_U;
               2'd1: ch = CH_L;
               2'd2: ch = CH_L;
               2'd3: ch = CH_NUL;
            endcase
         end
      endcase
      return ch;
   endfunction

   function automatic logic [1:0] lit_last_pos(input logic [1:0] which);
      return (which == LIT_FALSE) ? 2'd3 : 2'd2;
   endfunction

   function automatic tok_kind_type lit_kind(input logic [1:0] which);
      tok_kind_type k;
      unique case (which)
         LIT_TRUE:  k = TOK_TRUE;
         LIT_FALSE: k = TOK_FALSE;
         default:   k = TOK_NULL;
      endcase
      return k;
   endfunction

   function automatic tok_kind_type lit_err_kind(input logic [1:0] which);
      tok_kind_type k;
      unique case (which)
         LIT_TRUE:  k = TOK_ERR_TRUE;
         LIT_FALSE: k = TOK_ERR_FALSE;
         default:   k = TOK_ERR_NULL;
      endcase
      return k;
   endfunction

endpackage

// File: design/jsts_scan.sv
// ----------------------------------------------------------------------------
// jsts_scan
// Scanner state and the next-state update for one byte or end mark; gives
// up to two results per transfer.
// ----------------------------------------------------------------------------
module jsts_scan
   import jsts_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            step_en,
   input  logic [7:0]      in_byte,
   input  logic            end_of_input,
   output result_pair_type pair
);

   phase_type   phase_ff, phase_in;
   logic        digits_ff, digits_in;
   logic        neg_ff, neg_in;
   logic [63:0] acc_ff, acc_in;
   logic        ovf_ff, ovf_in;
   logic [1:0]  pos_ff, pos_in;
   logic [1:0]  which_ff, which_in;

   logic [67:0] acc_times10;
   logic [67:0] acc_sum;
   logic [63:0] acc_step;
   logic        ovf_step;
   logic [63:0] acc_neg;
   result_type  fin_res;
   result_type  a_res, b_res;
   logic        a_valid, b_valid;
   logic        finish, clear, redo;
   logic        dig, expmark;

   assign dig     = is_digit(in_byte);
   assign expmark = (in_byte == CH_E) || (in_byte == CH_UP_E);

   assign acc_times10 = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0};
   assign acc_sum     = acc_times10 + {64'd0, in_byte[3:0]};
   assign ovf_step    = ovf_ff || (acc_sum[67:64] != 4'd0);
   assign acc_step    = ovf_step ? {64{1'b1}} : acc_sum[63:0];
   assign acc_neg     = (~acc_ff) + 64'd1;

   always_comb begin
      fin_res = '0;
      if (phase_ff == PH_INT) begin
         if (!digits_ff) begin
            fin_res.token_kind = TOK_ERR_NUM;
         end else if (neg_ff) begin
            fin_res.token_kind = TOK_INT;
            if (ovf_ff || (acc_ff[63] && (acc_ff[62:0] != 63'd0))) begin
               fin_res.token_value   = {1'b1, 63'd0};
               fin_res.overflow_flag = 1'b1;
            end else begin
               fin_res.token_value = acc_neg;
            end
         end else if (!acc_ff[63]) begin
            fin_res.token_kind  = TOK_INT;
            fin_res.token_value = acc_ff;
         end else begin
            fin_res.token_kind    = TOK_NAT;
            fin_res.token_value   = acc_ff;
            fin_res.overflow_flag = ovf_ff;
         end
      end else if ((phase_ff == PH_FRAC || phase_ff == PH_EXPDIG) && digits_ff) begin
         fin_res.token_kind = TOK_REAL;
      end else begin
         fin_res.token_kind = TOK_ERR_REAL;
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      digits_in = digits_ff;
      neg_in    = neg_ff;
      acc_in    = acc_ff;
      ovf_in    = ovf_ff;
      pos_in    = pos_ff;
      which_in  = which_ff;
      a_valid   = 1'b0;
      a_res     = '0;
      b_valid   = 1'b0;
      b_res     = '0;
      b_res.last_result = 1'b1;
      finish    = 1'b0;
      clear     = 1'b0;
      redo      = 1'b0;

      unique case (phase_ff)
         PH_LIT: begin
            if (end_of_input) begin
               a_valid          = 1'b1;
               a_res.token_kind = lit_err_kind(which_ff);
               phase_in         = PH_IDLE;
               redo             = 1'b1;
            end else if (in_byte == lit_char(which_ff, pos_ff)) begin
               if (pos_ff >= lit_last_pos(which_ff)) begin
                  a_valid          = 1'b1;
                  a_res.token_kind = lit_kind(which_ff);
                  phase_in         = PH_IDLE;
                  pos_in           = 2'd0;
               end else begin
                  pos_in = pos_ff + 2'd1;
               end
            end else begin
               a_valid          = 1'b1;
               a_res.token_kind = lit_err_kind(which_ff);
               phase_in         = PH_IDLE;
               pos_in           = 2'd0;
            end
         end
         PH_INT: begin
            if (end_of_input) begin
               finish = 1'b1;
            end else if (dig) begin
               acc_in    = acc_step;
               ovf_in    = ovf_step;
               digits_in = 1'b1;
            end else if (in_byte == CH_DOT || expmark) begin
               if (!digits_ff) begin
                  a_valid          = 1'b1;
                  a_res.token_kind = TOK_ERR_NUM;
                  phase_in         = PH_IDLE;
                  clear            = 1'b1;
               end else begin
                  phase_in  = expmark ? PH_EXPSIGN : PH_FRAC;
                  digits_in = 1'b0;
               end
            end else begin
               finish = 1'b1;
            end
         end
         PH_FRAC: begin
            if (end_of_input) begin
               finish = 1'b1;
            end else if (dig) begin
               digits_in = 1'b1;
            end else if (expmark) begin
               if (!digits_ff) begin
                  a_valid          = 1'b1;
                  a_res.token_kind = TOK_ERR_REAL;
                  phase_in         = PH_IDLE;
                  clear            = 1'b1;
               end else begin
                  phase_in  = PH_EXPSIGN;
                  digits_in = 1'b0;
               end
            end else begin
               finish = 1'b1;
            end
         end
         PH_EXPSIGN: begin
            if (end_of_input) begin
               finish = 1'b1;
            end else if (dig) begin
               phase_in  = PH_EXPDIG;
               digits_in = 1'b1;
            end else if (in_byte == CH_MINUS || in_byte == CH_PLUS) begin
               phase_in  = PH_EXPDIG;
               digits_in = 1'b0;
            end else begin
               a_valid          = 1'b1;
               a_res.token_kind = TOK_ERR_REAL;
               phase_in         = PH_IDLE;
               clear            = 1'b1;
            end
         end
         PH_EXPDIG: begin
            if (!end_of_input && dig) begin
               digits_in = 1'b1;
            end else begin
               finish = 1'b1;
            end
         end
         default: begin
            phase_in = PH_IDLE;
            redo     = 1'b1;
         end
      endcase

      if (finish) begin
         a_valid  = 1'b1;
         a_res    = fin_res;
         phase_in = PH_IDLE;
         clear    = 1'b1;
         redo     = 1'b1;
      end

      if (clear) begin
         digits_in = 1'b0;
         neg_in    = 1'b0;
         acc_in    = 64'd0;
         ovf_in    = 1'b0;
      end

      if (redo) begin
         if (end_of_input) begin
            pos_in           = 2'd0;
            b_valid          = 1'b1;
            b_res.token_kind = TOK_END;
         end else if (is_space(in_byte)) begin
            b_valid = 1'b0;
         end else if (in_byte == CH_T || in_byte == CH_F || in_byte == CH_N) begin
            phase_in = PH_LIT;
            pos_in   = 2'd0;
            which_in = (in_byte == CH_T) ? LIT_TRUE :
                       ((in_byte == CH_F) ? LIT_FALSE : LIT_NULL);
         end else if (in_byte == CH_MINUS || dig) begin
            phase_in  = PH_INT;
            ovf_in    = 1'b0;
            neg_in    = !dig;
            digits_in = dig;
            acc_in    = dig ? {60'd0, in_byte[3:0]} : 64'd0;
         end else begin
            b_valid           = 1'b1;
            b_res.token_kind  = TOK_OTHER;
            b_res.passed_byte = in_byte;
         end
      end
   end

   always_comb begin
      pair = '0;
      if (a_valid) begin
         pair.res_first             = a_res;
         pair.res_first.last_result = !b_valid;
         pair.res_second            = b_res;
         pair.count                 = b_valid ? 2'd2 : 2'd1;
      end else begin
         pair.res_first  = b_res;
         pair.res_second = b_res;
         pair.count      = b_valid ? 2'd1 : 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         digits_ff <= 1'b0;
         neg_ff    <= 1'b0;
         acc_ff    <= 64'd0;
         ovf_ff    <= 1'b0;
         pos_ff    <= 2'd0;
         which_ff  <= 2'd0;
      end else if (step_en) begin
         phase_ff  <= phase_in;
         digits_ff <= digits_in;
         neg_ff    <= neg_in;
         acc_ff    <= acc_in;
         ovf_ff    <= ovf_in;
         pos_ff    <= pos_in;
         which_ff  <= which_in;
      end
   end

endmodule

// File: design/jsts_rsp_fifo.sv
// ----------------------------------------------------------------------------
// jsts_rsp_fifo
// Small result queue that takes zero, one or two results per cycle and
// presents its oldest result to the output channel, one per cycle while rd_en is high.
// ----------------------------------------------------------------------------
module jsts_rsp_fifo
   import jsts_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  result_pair_type       wr_pair,
   input  logic                  rd_en,
   output result_type            rd_data,
   output logic [FIFO_PTR_W:0]   fill
);

   result_type              entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]   wr_ptr_next;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_PTR_W:0]     fill_ff, fill_in;
   logic [1:0]              wr_count;

   assign wr_count    = wr_en ? wr_pair.count : 2'd0;
   assign wr_ptr_next = wr_ptr_ff + FIFO_PTR_W'(1);
   assign wr_ptr_in   = wr_ptr_ff + FIFO_PTR_W'(wr_count);
   assign rd_ptr_in   = rd_ptr_ff + FIFO_PTR_W'(rd_en);
   assign fill_in     = fill_ff + (FIFO_PTR_W + 1)'(wr_count) - (FIFO_PTR_W + 1)'(rd_en);
   assign rd_data     = entry_ff[rd_ptr_ff];
   assign fill        = fill_ff;

   always_ff @(posedge clock) begin
      if (wr_count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= wr_pair.res_first;
      end
      if (wr_count == 2'd2) begin
         entry_ff[wr_ptr_next] <= wr_pair.res_second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

// File: design/json_scalar_token_scanner.sv
// ----------------------------------------------------------------------------
// json_scalar_token_scanner
// Results enter the result queue at their input transfer and leave it in order.
// Throughput: one byte per cycle while the queue has room; one registered scanner update.
// A byte that ends a number and also yields a result puts two results in the queue.
// Input is taken while the four-entry result queue has at least two free entries.
// Reset is synchronous; it returns the scanner to idle and empties the queue.
// ----------------------------------------------------------------------------
module json_scalar_token_scanner
   import jsts_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,   // [7:0] in_byte
   input  logic [0:0]             req_tuser,   // [0] end_of_input
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // [63:0] token_value, [64] overflow_flag,
                                               // [72:65] passed_byte, [79:73] zero
   output logic [3:0]             rsp_tuser,   // [3:0] token_kind
   output logic                   rsp_tlast    // last_result
);

   result_pair_type       pair;
   result_type            head;
   logic [FIFO_PTR_W:0]   fill;
   logic                  req_xfer;
   logic                  rsp_xfer;

   assign req_tready = fill <= (FIFO_PTR_W + 1)'(FIFO_DEPTH - 2);
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_tvalid = fill != '0;
   assign rsp_xfer   = rsp_tvalid && rsp_tready;

   jsts_scan u_scan (
      .clock        (clock),
      .reset        (reset),
      .step_en      (req_xfer),
      .in_byte      (req_tdata),
      .end_of_input (req_tuser[0]),
      .pair         (pair)
   );

   jsts_rsp_fifo u_rsp_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (req_xfer),
      .wr_pair (pair),
      .rd_en   (rsp_xfer),
      .rd_data (head),
      .fill    (fill)
   );

   assign rsp_tdata = {7'd0, head.passed_byte, head.overflow_flag, head.token_value};
   assign rsp_tuser = head.token_kind;
   assign rsp_tlast = head.last_result;

`ifndef ASSERT_OFF
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill <= (FIFO_PTR_W + 1)'(FIFO_DEPTH))
      else $error("result queue overfilled");

   a_result_shows: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && pair.count != 2'd0) |=> rsp_tvalid)
      else $error("accepted transfer produced no visible result");

   a_end_result: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_tuser[0]) |-> (pair.count != 2'd0))
      else $error("end of input gave no result");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == TOK_END) |-> rsp_tlast)
      else $error("end result not marked last");
`endif

endmodule

// File: tb/sv/tb_json_scalar_token_scanner.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_json_scalar_token_scanner
// Self-checking bench for the JSON scalar token scanner. A short table of
// byte transfers after reset covers byte extremes, literals, the number
// phases and all error kinds but the null one; random token text follows:
// numbers near the 64-bit limits, whole and broken literals, whitespace,
// punctuation, noise and end marks. A bit-level scanner model predicts the
// tokens of random text and untyped rows. Both stream sides stall at random.
// ----------------------------------------------------------------------------
module tb_json_scalar_token_scanner;
   import jsts_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int RANDOM_ITEMS = 1000;

   typedef struct {
      tok_kind_type kind;
      logic [63:0]  value;
      logic         ovf;
      logic [7:0]   pbyte;
      logic         last;
   } token_type;

   typedef struct {
      logic [7:0]   b;
      bit           eoi;
      bit           typed;
      int           n;
      tok_kind_type k0;
      tok_kind_type k1;
   } scan_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata = 8'h00;
   logic [0:0]             req_tuser = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [3:0]             rsp_tuser;
   logic                   rsp_tlast;

   token_type   expected_tokens[$];
   token_type   table_tokens[$];
   bit          use_table = 1'b0;
   bit          gaps_on = 1'b1;
   int          mismatches = 0;
   int          quiet_cycles = 0;

   phase_type   scan_ph = PH_IDLE;
   bit          dig_seen = 1'b0;
   bit          neg = 1'b0;
   logic [63:0] acc = 64'd0;
   bit          acc_ovf = 1'b0;
   logic [2:0]  lit_pos = 3'd0;
   logic [1:0]  lit_sel = 2'd0;
   string       lit_tails[3] = '{"rue", "alse", "ull"};

   json_scalar_token_scanner u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #4 clock = ~clock;

   function automatic void emit(ref token_type q[$], input tok_kind_type k,
                                input logic [63:0] v, input logic f, input logic [7:0] pb);
      q.push_back('{k, v, f, pb, 1'b0});
   endfunction

   function automatic void clear_number();
      dig_seen = 1'b0;
      neg = 1'b0;
      acc = 64'd0;
      acc_ovf = 1'b0;
   endfunction

   function automatic void add_digit(input logic [7:0] b);
      logic [63:0] d;
      d = 64'(b - CH_0);
      if (acc_ovf || acc > (64'hFFFF_FFFF_FFFF_FFFF - d) / 64'd10) begin
         acc_ovf = 1'b1;
         acc = 64'hFFFF_FFFF_FFFF_FFFF;
      end else begin
         acc = acc * 64'd10 + d;
      end
   endfunction

   function automatic void finish_number(ref token_type q[$]);
      logic [63:0] lim;
      lim = 64'h8000_0000_0000_0000;
      if (scan_ph == PH_INT) begin
         if (!dig_seen) begin
            emit(q, TOK_ERR_NUM, 64'd0, 1'b0, 8'h00);
         end else if (neg) begin
            if (acc_ovf || acc > lim) begin
               emit(q, TOK_INT, lim, 1'b1, 8'h00);
            end else begin
               emit(q, TOK_INT, 64'd0 - acc, 1'b0, 8'h00);
            end
         end else if (acc < lim) begin
            emit(q, TOK_INT, acc, 1'b0, 8'h00);
         end else begin
            emit(q, TOK_NAT, acc, acc_ovf, 8'h00);
         end
      end else if ((scan_ph == PH_FRAC || scan_ph == PH_EXPDIG) && dig_seen) begin
         emit(q, TOK_REAL, 64'd0, 1'b0, 8'h00);
      end else begin
         emit(q, TOK_ERR_REAL, 64'd0, 1'b0, 8'h00);
      end
      scan_ph = PH_IDLE;
      clear_number();
   endfunction

   function automatic void idle_byte(input logic [7:0] b, ref token_type q[$]);
      if (b inside {CH_NUL, CH_TAB, CH_LF, CH_CR, CH_SPACE}) return;
      if (b == CH_T || b == CH_F || b == CH_N) begin
         scan_ph = PH_LIT;
         lit_pos = 3'd0;
         lit_sel = (b == CH_T) ? LIT_TRUE : ((b == CH_F) ? LIT_FALSE : LIT_NULL);
      end else if (b == CH_MINUS || (b >= CH_0 && b <= CH_9)) begin
         clear_number();
         scan_ph = PH_INT;
         if (b == CH_MINUS) begin
            neg = 1'b1;
         end else begin
            dig_seen = 1'b1;
            acc = 64'(b - CH_0);
         end
      end else begin
         emit(q, TOK_OTHER, 64'd0, 1'b0, b);
      end
   endfunction

   function automatic bit number_byte(input logic [7:0] b, ref token_type q[$]);
      bit dig;
      bit mark;
      bit redo;
      dig = (b >= CH_0 && b <= CH_9);
      mark = (b == CH_E || b == CH_UP_E);
      redo = 1'b1;
      case (scan_ph)
         PH_INT: begin
            if (dig) begin
               add_digit(b);
               dig_seen = 1'b1;
               redo = 1'b0;
            end else if (b == CH_DOT || mark) begin
               redo = 1'b0;
               if (!dig_seen) begin
                  emit(q, TOK_ERR_NUM, 64'd0, 1'b0, 8'h00);
                  scan_ph = PH_IDLE;
                  clear_number();
               end else begin
                  scan_ph = mark ? PH_EXPSIGN : PH_FRAC;
                  dig_seen = 1'b0;
               end
            end
         end
         PH_FRAC: begin
            if (dig) begin
               dig_seen = 1'b1;
               redo = 1'b0;
            end else if (mark) begin
               redo = 1'b0;
               if (!dig_seen) begin
                  emit(q, TOK_ERR_REAL, 64'd0, 1'b0, 8'h00);
                  scan_ph = PH_IDLE;
                  clear_number();
               end else begin
                  scan_ph = PH_EXPSIGN;
                  dig_seen = 1'b0;
               end
            end
         end
         PH_EXPSIGN: begin
            redo = 1'b0;
            scan_ph = PH_EXPDIG;
            if (dig) begin
               dig_seen = 1'b1;
            end else if (b == CH_MINUS || b == CH_PLUS) begin
               dig_seen = 1'b0;
            end else begin
               emit(q, TOK_ERR_REAL, 64'd0, 1'b0, 8'h00);
               scan_ph = PH_IDLE;
               clear_number();
            end
         end
         default: begin
            if (dig) begin
               dig_seen = 1'b1;
               redo = 1'b0;
            end
         end
      endcase
      if (redo) finish_number(q);
      return redo;
   endfunction

   function automatic void scan_step(input logic [7:0] b, input bit eoi, ref token_type q[$]);
      bit redo;
      int w;
      redo = 1'b1;
      w = (lit_sel > 2'd2) ? 2 : int'(lit_sel);
      if (scan_ph == PH_LIT) begin
         redo = 1'b0;
         if (eoi) begin
            emit(q, tok_kind_type'(TOK_ERR_TRUE + w), 64'd0, 1'b0, 8'h00);
            scan_ph = PH_IDLE;
            redo = 1'b1;
         end else if (lit_pos < lit_tails[w].len() && b == lit_tails[w][lit_pos]) begin
            lit_pos = lit_pos + 3'd1;
            if (lit_pos >= lit_tails[w].len()) begin
               emit(q, tok_kind_type'(TOK_TRUE + w), 64'd0, 1'b0, 8'h00);
               scan_ph = PH_IDLE;
               lit_pos = 3'd0;
            end
         end else begin
            emit(q, tok_kind_type'(TOK_ERR_TRUE + w), 64'd0, 1'b0, 8'h00);
            scan_ph = PH_IDLE;
            lit_pos = 3'd0;
         end
      end else if (scan_ph inside {PH_INT, PH_FRAC, PH_EXPSIGN, PH_EXPDIG}) begin
         if (eoi) begin
            finish_number(q);
         end else begin
            redo = number_byte(b, q);
         end
      end else begin
         scan_ph = PH_IDLE;
      end
      if (redo) begin
         if (eoi) begin
            lit_pos = 3'd0;
            emit(q, TOK_END, 64'd0, 1'b0, 8'h00);
         end else begin
            idle_byte(b, q);
         end
      end
      if (q.size() > 0) q[q.size() - 1].last = 1'b1;
   endfunction

   task automatic send(input logic [7:0] b, input bit eoi);
      token_type fresh[$];
      while (gaps_on && $urandom_range(0, 99) < 21) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tuser <= eoi;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      scan_step(b, eoi, fresh);
      if (use_table) begin
         foreach (table_tokens[i]) expected_tokens.push_back(table_tokens[i]);
      end else begin
         foreach (fresh[i]) expected_tokens.push_back(fresh[i]);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_tokens.size() != 0);
   endtask

   task automatic check_token();
      token_type want;
      if (expected_tokens.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("Unexpected token: kind %0d value %h", rsp_tuser, rsp_tdata[63:0]);
      end else begin
         want = expected_tokens.pop_front();
         if (rsp_tuser !== want.kind || rsp_tdata[63:0] !== want.value ||
             rsp_tdata[64] !== want.ovf || rsp_tdata[72:65] !== want.pbyte ||
             rsp_tlast !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Token mismatch: expected kind %0d value %h ovf %b byte %h last %b,",
                        want.kind, want.value, want.ovf, want.pbyte, want.last,
                        " got kind %0d value %h ovf %b byte %h last %b",
                        rsp_tuser, rsp_tdata[63:0], rsp_tdata[64], rsp_tdata[72:65],
                        rsp_tlast);
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_token();
      rsp_tready <= !(gaps_on && $urandom_range(0, 99) < 21);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      scan_row_type directed_rows[25];
      logic [7:0]  text[$];
      string       boundary[7];
      string       words[3];
      string       punct;
      logic [7:0]  ws[5];
      int          sent_items;
      int          r;
      int          nd;
      int          w;
      int          cut;
      bit          drained;

      directed_rows = '{
         '{8'hA5, 1'b1, 1'b1, 1, TOK_END,      TOK_END},
         '{8'h00, 1'b0, 1'b1, 0, TOK_END,      TOK_END},
         '{8'hFF, 1'b0, 1'b1, 1, TOK_OTHER,    TOK_END},
         '{"-",   1'b0, 1'b1, 0, TOK_END,      TOK_END},
         '{"x",   1'b0, 1'b1, 2, TOK_ERR_NUM,  TOK_OTHER},
         '{"f",   1'b0, 1'b1, 0, TOK_END,      TOK_END},
         '{"a",   1'b0, 1'b0, 0, TOK_END,      TOK_END},
         '{"x",   1'b0, 1'b1, 1, TOK_ERR_FALSE, TOK_END},
         '{"1",   1'b0, 1'b0, 0, TOK_END,      TOK_END},
         '{".",   1'b0, 1'b0, 0, TOK_END,      TOK_END},
         '{"5",   1'b0, 1'b0, 0, TOK_END,      TOK_END},
         '{"E",   1'b0, 1'b0, 0, TOK_END,      TOK_END},
         '{"+",   1'b0, 1'b0, 0, TOK_END,      TOK_END},
         '{"7",   1'b0, 1'b0, 0, TOK_END,      TOK_END},
         '{",",   1'b0, 1'b0, 0, TOK_END,      TOK_END},
         '{"-",   1'b0, 1'b0, 0, TOK_END,      TOK_END},
         '{".",   1'b0, 1'b1, 1, TOK_ERR_NUM,  TOK_END},
         '{"7",   1'b0, 1'b0, 0, TOK_END,      TOK_END},
         '{"e",   1'b0, 1'b0, 0, TOK_END,      TOK_END},
         '{"z",   1'b0, 1'b1, 1, TOK_ERR_REAL, TOK_END},
         '{"t",   1'b0, 1'b0, 0, TOK_END,      TOK_END},
         '{8'h5A, 1'b1, 1'b1, 2, TOK_ERR_TRUE, TOK_END},
         '{"4",   1'b0, 1'b0, 0, TOK_END,      TOK_END},
         '{"2",   1'b0, 1'b0, 0, TOK_END,      TOK_END},
         '{8'h00, 1'b1, 1'b0, 0, TOK_END,      TOK_END}
      };
      boundary = '{"9223372036854775807", "9223372036854775808", "18446744073709551615",
                   "18446744073709551616", "99999999999999999999999", "0", "007"};
      words = '{"true", "false", "null"};
      punct = ",:[]{}\"";
      ws = '{CH_NUL, CH_TAB, CH_LF, CH_CR, CH_SPACE};
      sent_items = 0;
      drained = 1'b0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         use_table = directed_rows[i].typed;
         table_tokens.delete();
         if (directed_rows[i].n >= 1)
            table_tokens.push_back('{directed_rows[i].k0, 64'd0, 1'b0,
               (directed_rows[i].k0 == TOK_OTHER) ? directed_rows[i].b : 8'h00,
               directed_rows[i].n == 1});
         if (directed_rows[i].n == 2)
            table_tokens.push_back('{directed_rows[i].k1, 64'd0, 1'b0,
               (directed_rows[i].k1 == TOK_OTHER) ? directed_rows[i].b : 8'h00, 1'b1});
         send(directed_rows[i].b, directed_rows[i].eoi);
      end
      use_table = 1'b0;
      drain();

      while (sent_items < RANDOM_ITEMS) begin
         text.delete();
         r = $urandom_range(0, 99);
         if (r < 32) begin
            if ($urandom_range(0, 9) == 0) text.push_back(CH_MINUS);
            if ($urandom_range(0, 7) == 0) begin
               w = $urandom_range(0, 6);
               for (int k = 0; k < boundary[w].len(); k++) text.push_back(boundary[w][k]);
            end else begin
               nd = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 22) : $urandom_range(1, 5);
               if ($urandom_range(0, 19) == 0) nd = 0;
               repeat (nd) text.push_back(CH_0 + 8'($urandom_range(0, 9)));
            end
            if ($urandom_range(0, 2) == 0) begin
               text.push_back(CH_DOT);
               nd = ($urandom_range(0, 12) == 0) ? 0 : $urandom_range(1, 3);
               repeat (nd) text.push_back(CH_0 + 8'($urandom_range(0, 9)));
            end
            if ($urandom_range(0, 3) == 0) begin
               text.push_back($urandom_range(0, 1) ? CH_E : CH_UP_E);
               r = $urandom_range(0, 2);
               if (r == 1) text.push_back(CH_MINUS);
               if (r == 2) text.push_back(CH_PLUS);
               nd = ($urandom_range(0, 12) == 0) ? 0 : $urandom_range(1, 2);
               repeat (nd) text.push_back(CH_0 + 8'($urandom_range(0, 9)));
            end
         end else if (r < 47) begin
            w = $urandom_range(0, 2);
            cut = ($urandom_range(0, 4) == 0) ? $urandom_range(1, words[w].len() - 1)
                                              : words[w].len();
            for (int k = 0; k < cut; k++) text.push_back(words[w][k]);
            if (cut < words[w].len()) text.push_back(8'($urandom_range(0, 255)));
         end else if (r < 65) begin
            repeat ($urandom_range(1, 3)) text.push_back(ws[$urandom_range(0, 4)]);
         end else if (r < 80) begin
            text.push_back(punct[$urandom_range(0, punct.len() - 1)]);
         end else if (r < 93) begin
            text.push_back(8'($urandom_range(0, 255)));
         end else begin
            send(8'($urandom_range(0, 255)), 1'b1);
            sent_items++;
         end
         foreach (text[k]) send(text[k], 1'b0);
         sent_items += text.size();
         gaps_on = !(sent_items >= 400 && sent_items < 600);
         if (!drained && sent_items >= 700) begin
            drain();
            drained = 1'b1;
         end
      end

      drain();
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
